### design/lss_pkg.sv
// Package for the LIFO stack with search: request and response structs,
// operation codes, controller state type and control/status bundles.
// No dependencies.
`default_nettype none

package lss_pkg;

   localparam int LSS_DEPTH      = 8;
   localparam int LSS_DATA_WIDTH = 32;
   localparam int LSS_VALUE_W    = 32;
   localparam int LSS_FILL_W     = 4;

   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;

   typedef struct packed {
      logic [1:0]                    req_type;
      logic signed [LSS_VALUE_W-1:0] value;
   } lss_req_type;

   typedef struct packed {
      logic                  found;
      logic                  rejected;
      logic                  is_full_flag;
      logic                  is_empty_flag;
      logic [LSS_FILL_W-1:0] fill_count;
   } lss_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } lss_state_type;

   // controller -> datapath
   typedef struct packed {
      logic exec_op;      // run push/pop/other and load its response
      logic scan_start;   // latch key, clear scan index and hit flag
      logic scan_issue;   // read entry at scan index, advance index
      logic load_search;  // load the search response
   } lss_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic scan_last;
   } lss_status_type;

endpackage

`default_nettype wire

### design/lifo_stack_with_search_top.sv
// Top level of the LIFO stack with search: joins controller and datapath.
// Depends on lss_pkg, lss_ctrl and lss_dpath.
//
//   channel | ports                           | direction | moves
//   --------+---------------------------------+-----------+----------------------
//   request | req_valid, req_ready, req_data  | in        | push/pop/search op
//   result  | rsp_valid, rsp_ready, rsp_data  | out       | flags and fill count
//
// Push, pop and the unused code finish at their acceptance edge: the result is
// registered there and shows in the next cycle. A search walks the occupied
// entries through the memory's registered read port, one entry a cycle, then
// goes through the drain and finish states, and finish registers its result
// (an empty stack skips to finish). Reset clears the fill count and the
// controller, not the entries. Outside a search a request is taken while the
// result slot is empty or being taken; a stalled result holds the request side.
`default_nettype none

module lifo_stack_with_search_top
   import lss_pkg::*;
#(
   parameter int DEPTH      = LSS_DEPTH,
   parameter int DATA_WIDTH = LSS_DATA_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire lss_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output lss_rsp_type      rsp_data
);

   lss_cmd_type    cmd;
   lss_status_type status;

   // sequence transactions and the search scan
   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the entries, the count and the result register
   lss_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_data)
   );

   // one transaction in flight: ready only when the result slot frees up
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("request taken while a result is stalled");

   // a full and an empty stack at once cannot be reported
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_full_flag && rsp_data.is_empty_flag))
      else $error("full and empty reported together");

   // a result never both finds and refuses
   a_found_not_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.rejected))
      else $error("found and rejected reported together");

   // a search taken holds the request side busy on the next cycle
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.req_type == REQ_SEARCH) |=> !req_ready)
      else $error("request taken during a search");

endmodule

`default_nettype wire

### design/lss_ctrl.sv
// Controller for the LIFO stack with search: handshake, response slot valid
// and the search scan sequencer. Depends on lss_pkg.
`default_nettype none

module lss_ctrl
   import lss_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [1:0]     req_op,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire lss_status_type status,
   output lss_cmd_type         cmd
);

   lss_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == REQ_SEARCH) begin
               state_in = status.empty ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.exec_op    = accept && (req_op != REQ_SEARCH);
            cmd.scan_start = accept && (req_op == REQ_SEARCH);
         end
         ST_SCAN:   cmd.scan_issue  = 1'b1;
         ST_DRAIN:  cmd             = '0;
         ST_FINISH: cmd.load_search = 1'b1;
         default:   cmd             = '0;
      endcase
   end

   always_comb begin
      priority if (cmd.exec_op || cmd.load_search) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### design/lss_dpath.sv
// Datapath for the LIFO stack with search: entry memory, fill counter,
// scan compare and the response register. Depends on lss_pkg.
`default_nettype none

module lss_dpath
   import lss_pkg::*;
#(
   parameter int DEPTH      = LSS_DEPTH,
   parameter int DATA_WIDTH = LSS_DATA_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire lss_req_type req,
   input  wire lss_cmd_type cmd,
   output lss_status_type   status,
   output lss_rsp_type      rsp
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] key_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic                  hit_ff, hit_in;
   lss_rsp_type           rsp_ff, rsp_in;

   logic [DATA_WIDTH+LSS_VALUE_W-1:0] key_ext;
   logic [DATA_WIDTH-1:0]             req_key;
   logic                              full;
   logic                              empty;
   logic                              do_push;
   logic                              do_pop;
   logic [CW+LSS_FILL_W-1:0]          fill_ext_op;
   logic [CW+LSS_FILL_W-1:0]          fill_ext_cur;

   // zero-extend, then keep the low DATA_WIDTH bits of the value
   assign key_ext = {{DATA_WIDTH{1'b0}}, req.value};
   assign req_key = key_ext[DATA_WIDTH-1:0];

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign do_push = cmd.exec_op && (req.req_type == REQ_PUSH) && !full;
   assign do_pop  = cmd.exec_op && (req.req_type == REQ_POP) && !empty;

   assign status.empty     = empty;
   assign status.scan_last = (CW'(idx_ff) == (cnt_ff - CW'(1)));

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_issue) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (cmd.scan_start) begin
         hit_in = 1'b0;
      end else if (rd_valid_ff && (rd_data_ff == key_ff)) begin
         hit_in = 1'b1;
      end
   end

   assign fill_ext_op  = {{LSS_FILL_W{1'b0}}, cnt_in};
   assign fill_ext_cur = {{LSS_FILL_W{1'b0}}, cnt_ff};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.exec_op) begin
         rsp_in.found         = 1'b0;
         rsp_in.rejected      = ((req.req_type == REQ_PUSH) && full) ||
                                ((req.req_type == REQ_POP) && empty);
         rsp_in.is_full_flag  = (cnt_in == FULL_CNT);
         rsp_in.is_empty_flag = (cnt_in == '0);
         rsp_in.fill_count    = fill_ext_op[LSS_FILL_W-1:0];
      end else if (cmd.load_search) begin
         rsp_in.found         = hit_ff;
         rsp_in.rejected      = 1'b0;
         rsp_in.is_full_flag  = full;
         rsp_in.is_empty_flag = empty;
         rsp_in.fill_count    = fill_ext_cur[LSS_FILL_W-1:0];
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[AW'(cnt_ff)] <= req_key;
      end
      if (cmd.scan_issue) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         rd_valid_ff <= cmd.scan_issue;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (cmd.scan_start) begin
         key_ff <= req_key;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire
